@@ rtl/core/mdbc_pkg.sv @@
// mdbc_pkg: shared types and constants of the multicore debug break coordinator
// action codes, controller states and the command and status bundles
// no dependencies
`default_nettype none

package mdbc_pkg;

  localparam int unsigned IDX_W    = 6;
  localparam int unsigned APIC_W   = 16;
  localparam int unsigned MASK_W   = 64;
  localparam int unsigned GRP_W    = 8;
  localparam int unsigned NUM_GRP  = MASK_W / GRP_W;
  localparam int unsigned GSEL_W   = $clog2(NUM_GRP);
  localparam int unsigned GOFF_W   = $clog2(GRP_W);
  localparam int unsigned MAX_IDX  = 64;

  typedef enum logic [2:0] {
    ACT_REGISTER    = 3'd0,
    ACT_SET_STOP    = 3'd1,
    ACT_SET_BREAK   = 3'd2,
    ACT_FIRST_BREAK = 3'd3,
    ACT_SET_RUNNING = 3'd4,
    ACT_SET_VIEW    = 3'd5,
    ACT_SET_AP_IPI  = 3'd6,
    ACT_CLEAR_OWNER = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_EXEC,
    ST_ENC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic read;
    logic step;
    logic exec;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic search_needed;
    logic match;
    logic last;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/core/multicore_debug_break_coordinator_top.sv @@
// Multicore debug break coordinator. One item is taken at a time. An item with no registry
// search passes capture, update, break encoder and result load, and result load waits while
// an older result is stalled. A register action on a non-empty registry adds a read and a
// compare step for each entry compared, match included, at most one per registered core,
// set by the single registry read port. The result register frees the input side while a
// result waits to be taken. Top level: ties the controller to the datapath
// depends on mdbc_pkg, mdbc_ctrl, mdbc_dpath
`default_nettype none

module multicore_debug_break_coordinator_top #(
  parameter int unsigned MAX_CORES = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [2:0]                    in_action,
  input  wire logic [mdbc_pkg::APIC_W-1:0]   in_apic_id,
  input  wire logic [mdbc_pkg::IDX_W-1:0]    in_cpu_index,
  input  wire logic                          in_flag,
  input  wire logic                          in_bsp_msr_bit,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [mdbc_pkg::IDX_W-1:0]         out_assigned_index,
  output logic                               out_registry_full,
  output logic                               out_is_first,
  output logic                               out_halt_others,
  output logic                               out_stopped,
  output logic                               out_all_running,
  output logic                               out_pending_valid,
  output logic [mdbc_pkg::IDX_W-1:0]         out_pending_index,
  output logic [mdbc_pkg::IDX_W-1:0]         out_view_point,
  output logic                               out_run_command,
  output logic                               out_ipi_by_ap,
  output logic [mdbc_pkg::IDX_W-1:0]         out_bsp_index
);

  mdbc_pkg::ctrl_cmd_t  cmd;
  mdbc_pkg::dp_status_t status;

  mdbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mdbc_dpath #(
    .MAX_CORES (MAX_CORES)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_action          (in_action),
    .in_apic_id         (in_apic_id),
    .in_cpu_index       (in_cpu_index),
    .in_flag            (in_flag),
    .in_bsp_msr_bit     (in_bsp_msr_bit),
    .cmd                (cmd),
    .status             (status),
    .out_assigned_index (out_assigned_index),
    .out_registry_full  (out_registry_full),
    .out_is_first       (out_is_first),
    .out_halt_others    (out_halt_others),
    .out_stopped        (out_stopped),
    .out_all_running    (out_all_running),
    .out_pending_valid  (out_pending_valid),
    .out_pending_index  (out_pending_index),
    .out_view_point     (out_view_point),
    .out_run_command    (out_run_command),
    .out_ipi_by_ap      (out_ipi_by_ap),
    .out_bsp_index      (out_bsp_index)
  );

endmodule

`default_nettype wire

@@ rtl/core/mdbc_ctrl.sv @@
// mdbc_ctrl: sequencing state machine and result channel valid
// depends on mdbc_pkg
`default_nettype none

module mdbc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire mdbc_pkg::dp_status_t status,
  output mdbc_pkg::ctrl_cmd_t       cmd
);

  mdbc_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             load_ok;

  assign load_ok = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mdbc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mdbc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = status.search_needed ? mdbc_pkg::ST_READ : mdbc_pkg::ST_EXEC;
        end
      end
      mdbc_pkg::ST_READ: state_nxt = mdbc_pkg::ST_CMP;
      mdbc_pkg::ST_CMP: begin
        if (status.match || status.last) begin
          state_nxt = mdbc_pkg::ST_EXEC;
        end else begin
          state_nxt = mdbc_pkg::ST_READ;
        end
      end
      mdbc_pkg::ST_EXEC: state_nxt = mdbc_pkg::ST_ENC;
      mdbc_pkg::ST_ENC:  state_nxt = mdbc_pkg::ST_OUT;
      mdbc_pkg::ST_OUT: begin
        if (load_ok) begin
          state_nxt = mdbc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mdbc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_stall     = 1'b1;
    case (state_r)
      mdbc_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      mdbc_pkg::ST_READ: cmd.read     = 1'b1;
      mdbc_pkg::ST_CMP:  cmd.step     = 1'b1;
      mdbc_pkg::ST_EXEC: cmd.exec     = 1'b1;
      mdbc_pkg::ST_ENC:  cmd          = '0;
      mdbc_pkg::ST_OUT:  cmd.load_out = load_ok;
      default:           cmd          = '0;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ rtl/core/mdbc_dpath.sv @@
// mdbc_dpath: registry memory, core masks, flags, break encoder and result register
// depends on mdbc_pkg
`default_nettype none

module mdbc_dpath #(
  parameter int unsigned MAX_CORES = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_wdata,
  input  wire logic [2:0]                    in_action,
  input  wire logic [mdbc_pkg::APIC_W-1:0]   in_apic_id,
  input  wire logic [mdbc_pkg::IDX_W-1:0]    in_cpu_index,
  input  wire logic                          in_flag,
  input  wire logic                          in_bsp_msr_bit,
  input  wire mdbc_pkg::ctrl_cmd_t           cmd,
  output mdbc_pkg::dp_status_t               status,
  output logic [mdbc_pkg::IDX_W-1:0]         out_assigned_index,
  output logic                               out_registry_full,
  output logic                               out_is_first,
  output logic                               out_halt_others,
  output logic                               out_stopped,
  output logic                               out_all_running,
  output logic                               out_pending_valid,
  output logic [mdbc_pkg::IDX_W-1:0]         out_pending_index,
  output logic [mdbc_pkg::IDX_W-1:0]         out_view_point,
  output logic                               out_run_command,
  output logic                               out_ipi_by_ap,
  output logic [mdbc_pkg::IDX_W-1:0]         out_bsp_index
);

  localparam int unsigned CAP    = (MAX_CORES < mdbc_pkg::MAX_IDX) ? MAX_CORES
                                                                    : mdbc_pkg::MAX_IDX;
  localparam int unsigned ADDR_W = $clog2(CAP);
  localparam int unsigned CNT_W  = ADDR_W + 1;

  // captured item
  mdbc_pkg::action_t               action_r;
  logic [mdbc_pkg::APIC_W-1:0]     apic_r;
  logic [mdbc_pkg::IDX_W-1:0]      cpu_r;
  logic                            flag_r;
  logic                            bsp_r;

  // registry
  logic [mdbc_pkg::APIC_W-1:0]     apic_mem [CAP];
  logic [mdbc_pkg::APIC_W-1:0]     rdata_r;
  logic [ADDR_W-1:0]               ptr_r;
  logic                            found_r;
  logic [CNT_W-1:0]                count_r, count_nxt;
  logic                            mem_we;

  // core state
  logic                            mp_support_r;
  logic [mdbc_pkg::MASK_W-1:0]     stop_r, stop_nxt;
  logic [mdbc_pkg::MASK_W-1:0]     brk_r, brk_nxt;
  logic                            owner_r, owner_nxt;
  logic [mdbc_pkg::IDX_W-1:0]      view_r, view_nxt;
  logic                            run_r, run_nxt;
  logic                            ipi_r, ipi_nxt;
  logic [mdbc_pkg::IDX_W-1:0]      bsp_idx_r, bsp_idx_nxt;

  // step results
  logic [mdbc_pkg::IDX_W-1:0]      res_assigned_r, res_assigned_nxt;
  logic                            res_full_r, res_full_nxt;
  logic                            res_first_r, res_first_nxt;
  logic                            res_halt_r, res_halt_nxt;

  // break encoder groups
  logic [mdbc_pkg::NUM_GRP-1:0]    grp_any_r;
  logic [mdbc_pkg::GOFF_W-1:0]     grp_off_r [mdbc_pkg::NUM_GRP];
  logic [mdbc_pkg::GOFF_W-1:0]     grp_off_nxt [mdbc_pkg::NUM_GRP];
  logic [mdbc_pkg::GSEL_W-1:0]     pend_grp;
  logic [mdbc_pkg::IDX_W-1:0]      pend_idx;

  assign status.search_needed = (in_action == mdbc_pkg::ACT_REGISTER) && (count_r != '0);
  assign status.match         = (rdata_r == apic_r);
  assign status.last          = (CNT_W'(ptr_r) + CNT_W'(1)) == count_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_r <= mdbc_pkg::action_t'(in_action);
      apic_r   <= in_apic_id;
      cpu_r    <= in_cpu_index;
      flag_r   <= in_flag;
      bsp_r    <= in_bsp_msr_bit;
      ptr_r    <= '0;
      found_r  <= 1'b0;
    end else if (cmd.step) begin
      found_r <= status.match;
      if (!status.match) begin
        ptr_r <= ptr_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      apic_mem[count_r[ADDR_W-1:0]] <= apic_r;
    end
    if (cmd.read) begin
      rdata_r <= apic_mem[ptr_r];
    end
  end

  always_comb begin
    count_nxt        = count_r;
    stop_nxt         = stop_r;
    brk_nxt          = brk_r;
    owner_nxt        = owner_r;
    view_nxt         = view_r;
    run_nxt          = run_r;
    ipi_nxt          = ipi_r;
    bsp_idx_nxt      = bsp_idx_r;
    res_assigned_nxt = '0;
    res_full_nxt     = 1'b0;
    res_first_nxt    = 1'b0;
    res_halt_nxt     = 1'b0;
    mem_we           = 1'b0;
    case (action_r)
      mdbc_pkg::ACT_REGISTER: begin
        if (found_r) begin
          res_assigned_nxt = mdbc_pkg::IDX_W'(ptr_r);
        end else if (count_r < CNT_W'(CAP)) begin
          mem_we           = cmd.exec;
          res_assigned_nxt = mdbc_pkg::IDX_W'(count_r);
          count_nxt        = count_r + CNT_W'(1);
        end else begin
          res_full_nxt = 1'b1;
        end
      end
      mdbc_pkg::ACT_SET_STOP:    stop_nxt[cpu_r] = flag_r;
      mdbc_pkg::ACT_SET_BREAK:   brk_nxt[cpu_r]  = flag_r;
      mdbc_pkg::ACT_FIRST_BREAK: begin
        if (!mp_support_r) begin
          res_first_nxt = 1'b1;
        end else if (owner_r) begin
          brk_nxt[cpu_r] = 1'b1;
        end else begin
          if (count_r >= CNT_W'(2)) begin
            if (bsp_r) begin
              bsp_idx_nxt = cpu_r;
            end else begin
              ipi_nxt = 1'b1;
            end
          end
          owner_nxt     = 1'b1;
          view_nxt      = cpu_r;
          res_first_nxt = 1'b1;
          res_halt_nxt  = 1'b1;
        end
      end
      mdbc_pkg::ACT_SET_RUNNING: run_nxt   = flag_r;
      mdbc_pkg::ACT_SET_VIEW:    view_nxt  = cpu_r;
      mdbc_pkg::ACT_SET_AP_IPI:  ipi_nxt   = flag_r;
      mdbc_pkg::ACT_CLEAR_OWNER: owner_nxt = 1'b0;
      default:                   owner_nxt = owner_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mp_support_r <= 1'b1;
      count_r      <= '0;
      stop_r       <= '0;
      brk_r        <= '0;
      owner_r      <= 1'b0;
      view_r       <= '0;
      run_r        <= 1'b0;
      ipi_r        <= 1'b0;
      bsp_idx_r    <= '0;
    end else begin
      if (cfg_we) begin
        mp_support_r <= cfg_wdata;
      end
      if (cmd.exec) begin
        count_r   <= count_nxt;
        stop_r    <= stop_nxt;
        brk_r     <= brk_nxt;
        owner_r   <= owner_nxt;
        view_r    <= view_nxt;
        run_r     <= run_nxt;
        ipi_r     <= ipi_nxt;
        bsp_idx_r <= bsp_idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_assigned_r <= res_assigned_nxt;
      res_full_r     <= res_full_nxt;
      res_first_r    <= res_first_nxt;
      res_halt_r     <= res_halt_nxt;
    end
  end

  // first level of the lowest break search, one byte per group
  always_comb begin
    for (int g = 0; g < mdbc_pkg::NUM_GRP; g++) begin
      grp_off_nxt[g] = '0;
      for (int j = mdbc_pkg::GRP_W - 1; j >= 0; j--) begin
        if (brk_r[g*mdbc_pkg::GRP_W + j]) begin
          grp_off_nxt[g] = mdbc_pkg::GOFF_W'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < mdbc_pkg::NUM_GRP; g++) begin
      grp_any_r[g] <= |brk_r[g*mdbc_pkg::GRP_W +: mdbc_pkg::GRP_W];
      grp_off_r[g] <= grp_off_nxt[g];
    end
  end

  always_comb begin
    pend_grp = '0;
    for (int g = mdbc_pkg::NUM_GRP - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        pend_grp = mdbc_pkg::GSEL_W'(g);
      end
    end
    pend_idx = {pend_grp, grp_off_r[pend_grp]};
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_assigned_index <= res_assigned_r;
      out_registry_full  <= res_full_r;
      out_is_first       <= res_first_r;
      out_halt_others    <= res_halt_r;
      out_stopped        <= stop_r[cpu_r];
      out_all_running    <= ~|stop_r;
      out_pending_valid  <= |grp_any_r;
      out_pending_index  <= (|grp_any_r) ? pend_idx : '0;
      out_view_point     <= view_r;
      out_run_command    <= run_r;
      out_ipi_by_ap      <= ipi_r;
      out_bsp_index      <= bsp_idx_r;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mdbc_checker.sv @@
// mdbc_checker: port level assertions for the coordinator top level
// depends on mdbc_pkg; bound to multicore_debug_break_coordinator_top
`default_nettype none

module mdbc_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [mdbc_pkg::IDX_W-1:0]    out_assigned_index,
  input wire logic                          out_registry_full,
  input wire logic                          out_is_first,
  input wire logic                          out_halt_others,
  input wire logic                          out_pending_valid,
  input wire logic [mdbc_pkg::IDX_W-1:0]    out_pending_index
);

  // one item in flight: a transfer in closes the input side
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pending_index)
      && $stable(out_assigned_index))
    else $error("stalled result changed");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_registry_full |-> out_assigned_index == '0 && !out_is_first)
    else $error("full registry with nonzero index or first break");

  a_halt_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_halt_others |-> out_is_first)
    else $error("halt request without first break");

  a_pend_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pending_valid |-> out_pending_index == '0)
    else $error("pending index without pending break");

endmodule

bind multicore_debug_break_coordinator_top mdbc_checker u_mdbc_checker (.*);

`default_nettype wire
